### hdl/vlam_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vlam_pkg
// shared widths, codes and record layouts of the voxel lru accumulator map
// ----------------------------------------------------------------------------
package vlam_pkg;

	localparam int TABLE_DEPTH     = 1024;
	localparam int COORD_FRAC_BITS = 16;
	localparam int INV_FRAC_BITS   = 16;
	localparam int FRAC_SHIFT      = COORD_FRAC_BITS + INV_FRAC_BITS;

	localparam int ADDR_W   = $clog2(TABLE_DEPTH);
	localparam int OCC_W    = $clog2(TABLE_DEPTH + 1);
	localparam int COORD_W  = 32;
	localparam int INV_W    = 24;
	localparam int MULT_W   = 32;
	localparam int MOD_W    = 63;
	localparam int CAP_W    = 11;
	localparam int KEY_W    = 64;
	localparam int COUNT_W  = 6;
	localparam int SUM_W    = 38;
	localparam int STATUS_W = 3;
	localparam int CMP_W    = 32;
	localparam int MUL_W    = 33;
	localparam int STEP_W   = $clog2(KEY_W);
	localparam int IDX_W    = COORD_W + INV_W + 1 - FRAC_SHIFT;
	localparam int MAX_POINTS = 50;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [INV_W-1:0]  INV_RES_RESET   = INV_W'(131072);
	localparam logic [MULT_W-1:0] HASH_MULT_RESET = MULT_W'(116101);
	localparam logic [MOD_W-1:0]  HASH_MOD_RESET  = MOD_W'(64'd10000000000);
	localparam logic [CAP_W-1:0]  CAPACITY_RESET  = CAP_W'(1024);

	typedef enum logic [STATUS_W-1:0] {
		STATUS_NEW      = 3'd0,
		STATUS_ACCUM    = 3'd1,
		STATUS_FULL     = 3'd2,
		STATUS_REPLACED = 3'd3,
		STATUS_CLEARED  = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_RES   = 2'd0,
		REG_HASH_MULT = 2'd1,
		REG_HASH_MOD  = 2'd2,
		REG_CAPACITY  = 2'd3
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE, ST_CLEAR, ST_SCALE, ST_SCALE_W, ST_HLO, ST_HHI, ST_HSUM,
		ST_MOD, ST_HNEXT, ST_SCAN, ST_SCAN_END, ST_DECIDE, ST_RANK, ST_RANK_END,
		ST_DRD, ST_DLAT, ST_CMUL, ST_CMUL_W, ST_CHK, ST_DIVSET, ST_DIV, ST_DIVFIN,
		ST_WRITE, ST_EMIT
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [ADDR_W-1:0] rank;
	} meta_t;

	typedef struct packed {
		logic [COUNT_W-1:0]        count;
		logic [2:0][SUM_W-1:0]     sum;
		logic [2:0][COORD_W-1:0]   cent;
	} data_t;

	typedef struct packed {
		status_t            status;
		logic [KEY_W-1:0]   key;
		logic [COUNT_W-1:0] count;
		logic [COORD_W-1:0] cent_x;
		logic [COORD_W-1:0] cent_y;
		logic [COORD_W-1:0] cent_z;
		logic               evicted;
		logic [KEY_W-1:0]   evicted_key;
	} res_t;

endpackage
`default_nettype wire

### hdl/vlam_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vlam channel interfaces
// point input, result output and register write channels
// ----------------------------------------------------------------------------
interface vlam_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 operation;
	logic signed [vlam_pkg::COORD_W-1:0]  point_x;
	logic signed [vlam_pkg::COORD_W-1:0]  point_y;
	logic signed [vlam_pkg::COORD_W-1:0]  point_z;
	modport source (output valid, operation, point_x, point_y, point_z, input ready);
	modport sink (input valid, operation, point_x, point_y, point_z, output ready);
endinterface

interface vlam_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [vlam_pkg::STATUS_W-1:0]        status;
	logic [vlam_pkg::KEY_W-1:0]           voxel_key;
	logic [vlam_pkg::COUNT_W-1:0]         voxel_count;
	logic signed [vlam_pkg::COORD_W-1:0]  centroid_x;
	logic signed [vlam_pkg::COORD_W-1:0]  centroid_y;
	logic signed [vlam_pkg::COORD_W-1:0]  centroid_z;
	logic                                 evicted;
	logic [vlam_pkg::KEY_W-1:0]           evicted_key;
	modport source (output valid, status, voxel_key, voxel_count, centroid_x, centroid_y,
		centroid_z, evicted, evicted_key, input ready);
	modport sink (input valid, status, voxel_key, voxel_count, centroid_x, centroid_y,
		centroid_z, evicted, evicted_key, output ready);
endinterface

interface vlam_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [vlam_pkg::CFG_IDX_W-1:0]    index;
	logic [vlam_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/vlam_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vlam_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module vlam_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### hdl/voxel_lru_accumulator_map_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_lru_accumulator_map_unit
// hashed voxel map with lru eviction: one q16.16 point per item
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  cfg       in   valid/ready    index, data (register write, always ready)
//  points    in   valid/ready    operation, point_x, point_y, point_z
//  results   out  valid/ready    status, voxel_key, voxel_count, centroid_x/y/z,
//                                evicted, evicted_key
//
//  one item at a time; an add raises its result once the table has been
//  walked once for the key search and once for the rank update through the
//  single read port of the entry ram, plus at most two 64-step hash modulo
//  runs and three 38-step centroid divisions; a clear walks the table once.
//  after reset a pass over the table marks every entry free before the
//  first item is taken.
//  a result waits in the output register while the next item is already
//  taken and worked on; that item then stalls until the register is free.

module voxel_lru_accumulator_map_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	vlam_cfg_if.sink    cfg,
	vlam_in_if.sink     points,
	vlam_out_if.source  results
);

	// configuration registers
	logic [vlam_pkg::INV_W-1:0]  inv_q;
	logic [vlam_pkg::MULT_W-1:0] mult_q;
	logic [vlam_pkg::MOD_W-1:0]  mod_q;
	logic [vlam_pkg::CAP_W-1:0]  cap_q;

	// sequencer
	vlam_pkg::state_t st_q, st_d;
	logic [vlam_pkg::ADDR_W-1:0] ctr_q;
	logic [1:0]                  ax_q;
	logic                        rnd_q;
	logic [vlam_pkg::STEP_W-1:0] step_q;

	// item and hash datapath
	logic [vlam_pkg::COORD_W-1:0]          pt_q   [3];
	logic [vlam_pkg::IDX_W-1:0]            hidx_q [3];
	logic [vlam_pkg::IDX_W-1:0]            fidx_q [3];
	logic signed [vlam_pkg::KEY_W-1:0]     mul_q;
	logic [vlam_pkg::KEY_W-1:0]            acc_q;
	logic [vlam_pkg::KEY_W-1:0]            rem_q;
	logic [vlam_pkg::KEY_W-1:0]            key_q;

	// scan results
	logic                        rd_vld_s1;
	logic [vlam_pkg::ADDR_W-1:0] rd_addr_s1;
	logic                        hit_q, free_q, tail_q;
	logic [vlam_pkg::ADDR_W-1:0] hit_slot_q, hit_rank_q, free_slot_q;
	logic [vlam_pkg::ADDR_W-1:0] tail_slot_q, tail_rank_q;
	logic [vlam_pkg::KEY_W-1:0]  tail_key_q;

	// per item decision
	logic [vlam_pkg::ADDR_W-1:0] slot_q;
	logic                        ev_q, cap_ev_q;
	logic [vlam_pkg::OCC_W-1:0]  occ_q;

	// voxel record and divider
	vlam_pkg::data_t             cur_q;
	logic                        mism_q, full_q;
	logic [vlam_pkg::SUM_W-1:0]  dq_q;
	logic [vlam_pkg::COUNT_W-1:0] drem_q;
	logic                        dneg_q;

	// result and output register
	vlam_pkg::res_t res_q, out_q;
	logic           out_vld_q;

	// rams
	logic                        meta_we, meta_re;
	logic [vlam_pkg::ADDR_W-1:0] meta_waddr, meta_raddr;
	vlam_pkg::meta_t             meta_wdata, meta_rd;
	logic                        data_we, data_re;
	vlam_pkg::data_t             data_wdata, data_rd, new_entry;

	// shared multiplier
	logic signed [vlam_pkg::MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*vlam_pkg::MUL_W-1:0] mul_full;

	// combinational helpers
	logic signed [vlam_pkg::KEY_W-1:0] shr;
	logic [vlam_pkg::IDX_W-1:0]        fl, hx;
	logic                              exact;
	logic [vlam_pkg::KEY_W-1:0]        rem_sh;
	logic [vlam_pkg::COUNT_W:0]        drem_sh;
	logic [vlam_pkg::SUM_W-1:0]        sum_sel, sum_mag, q_plus, cent_full;
	logic [vlam_pkg::CMP_W-1:0]        cap_eff, occ_next;
	logic                              ev_full, cap_ev;
	vlam_pkg::status_t                 status_d;
	logic [vlam_pkg::ADDR_W-1:0]       last_addr;

	assign last_addr = vlam_pkg::ADDR_W'(vlam_pkg::TABLE_DEPTH - 1);

	vlam_ram #(
		.WIDTH ($bits(vlam_pkg::meta_t)),
		.DEPTH (vlam_pkg::TABLE_DEPTH)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (meta_re),
		.raddr (meta_raddr),
		.rdata (meta_rd)
	);

	vlam_ram #(
		.WIDTH ($bits(vlam_pkg::data_t)),
		.DEPTH (vlam_pkg::TABLE_DEPTH)
	) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (slot_q),
		.wdata (data_wdata),
		.re    (data_re),
		.raddr (slot_q),
		.rdata (data_rd)
	);

	// configuration port, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q  <= vlam_pkg::INV_RES_RESET;
			mult_q <= vlam_pkg::HASH_MULT_RESET;
			mod_q  <= vlam_pkg::HASH_MOD_RESET;
			cap_q  <= vlam_pkg::CAPACITY_RESET;
		end else if (cfg.valid) begin
			case (vlam_pkg::cfg_reg_t'(cfg.index))
				vlam_pkg::REG_INV_RES:   inv_q  <= cfg.data[vlam_pkg::INV_W-1:0];
				vlam_pkg::REG_HASH_MULT: mult_q <= cfg.data[vlam_pkg::MULT_W-1:0];
				vlam_pkg::REG_HASH_MOD:  mod_q  <= cfg.data[vlam_pkg::MOD_W-1:0];
				vlam_pkg::REG_CAPACITY:  cap_q  <= cfg.data[vlam_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			vlam_pkg::ST_INIT:     if (ctr_q == last_addr) st_d = vlam_pkg::ST_IDLE;
			vlam_pkg::ST_IDLE: begin
				if (points.valid) begin
					st_d = points.operation ? vlam_pkg::ST_CLEAR : vlam_pkg::ST_SCALE;
				end
			end
			vlam_pkg::ST_CLEAR:    if (ctr_q == last_addr) st_d = vlam_pkg::ST_EMIT;
			vlam_pkg::ST_SCALE:    st_d = vlam_pkg::ST_SCALE_W;
			vlam_pkg::ST_SCALE_W:  st_d = (ax_q == 2'd2) ? vlam_pkg::ST_HLO : vlam_pkg::ST_SCALE;
			vlam_pkg::ST_HLO:      st_d = vlam_pkg::ST_HHI;
			vlam_pkg::ST_HHI:      st_d = vlam_pkg::ST_HSUM;
			vlam_pkg::ST_HSUM:     st_d = (mod_q != '0) ? vlam_pkg::ST_MOD : vlam_pkg::ST_HNEXT;
			vlam_pkg::ST_MOD: begin
				if (step_q == vlam_pkg::STEP_W'(vlam_pkg::KEY_W - 1)) st_d = vlam_pkg::ST_HNEXT;
			end
			vlam_pkg::ST_HNEXT:    st_d = rnd_q ? vlam_pkg::ST_SCAN : vlam_pkg::ST_HLO;
			vlam_pkg::ST_SCAN:     if (ctr_q == last_addr) st_d = vlam_pkg::ST_SCAN_END;
			vlam_pkg::ST_SCAN_END: st_d = vlam_pkg::ST_DECIDE;
			vlam_pkg::ST_DECIDE:   st_d = vlam_pkg::ST_RANK;
			vlam_pkg::ST_RANK:     if (ctr_q == last_addr) st_d = vlam_pkg::ST_RANK_END;
			vlam_pkg::ST_RANK_END: st_d = vlam_pkg::ST_DRD;
			vlam_pkg::ST_DRD:      st_d = vlam_pkg::ST_DLAT;
			vlam_pkg::ST_DLAT:     st_d = hit_q ? vlam_pkg::ST_CMUL : vlam_pkg::ST_WRITE;
			vlam_pkg::ST_CMUL:     st_d = vlam_pkg::ST_CMUL_W;
			vlam_pkg::ST_CMUL_W:   st_d = (ax_q == 2'd2) ? vlam_pkg::ST_CHK : vlam_pkg::ST_CMUL;
			vlam_pkg::ST_CHK: begin
				if (!mism_q && cur_q.count < vlam_pkg::COUNT_W'(vlam_pkg::MAX_POINTS)) begin
					st_d = vlam_pkg::ST_DIVSET;
				end else begin
					st_d = vlam_pkg::ST_WRITE;
				end
			end
			vlam_pkg::ST_DIVSET:   st_d = vlam_pkg::ST_DIV;
			vlam_pkg::ST_DIV: begin
				if (step_q == vlam_pkg::STEP_W'(vlam_pkg::SUM_W - 1)) st_d = vlam_pkg::ST_DIVFIN;
			end
			vlam_pkg::ST_DIVFIN:   st_d = (ax_q == 2'd2) ? vlam_pkg::ST_WRITE : vlam_pkg::ST_DIVSET;
			vlam_pkg::ST_WRITE:    st_d = vlam_pkg::ST_EMIT;
			vlam_pkg::ST_EMIT:     if (!out_vld_q || results.ready) st_d = vlam_pkg::ST_IDLE;
			default:               st_d = vlam_pkg::ST_IDLE;
		endcase
	end

	// ram controls, multiplier operands, handshake
	always_comb begin
		points.ready = (st_q == vlam_pkg::ST_IDLE);
		meta_re      = (st_q == vlam_pkg::ST_SCAN) || (st_q == vlam_pkg::ST_RANK);
		meta_raddr   = ctr_q;
		meta_we      = 1'b0;
		meta_waddr   = rd_addr_s1;
		meta_wdata   = meta_rd;
		data_re      = (st_q == vlam_pkg::ST_DRD);
		data_we      = (st_q == vlam_pkg::ST_WRITE);
		mul_a        = '0;
		mul_b        = '0;

		case (st_q)
			vlam_pkg::ST_INIT, vlam_pkg::ST_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = ctr_q;
				meta_wdata = '0;
			end
			vlam_pkg::ST_RANK, vlam_pkg::ST_RANK_END: begin
				meta_we = rd_vld_s1;
				if (rd_addr_s1 == slot_q) begin
					meta_wdata.valid = 1'b1;
					meta_wdata.key   = key_q;
					meta_wdata.rank  = '0;
				end else if (cap_ev_q && rd_addr_s1 == tail_slot_q) begin
					meta_wdata.valid = 1'b0;
				end else if (meta_rd.valid && (!hit_q || meta_rd.rank < hit_rank_q)) begin
					meta_wdata.rank = meta_rd.rank + vlam_pkg::ADDR_W'(1);
				end
			end
			vlam_pkg::ST_SCALE: begin
				mul_a = {pt_q[ax_q][vlam_pkg::COORD_W-1], pt_q[ax_q]};
				mul_b = {{(vlam_pkg::MUL_W - vlam_pkg::INV_W){1'b0}}, inv_q};
			end
			vlam_pkg::ST_HLO: begin
				mul_a = {1'b0, acc_q[vlam_pkg::MULT_W-1:0]};
				mul_b = {1'b0, mult_q};
			end
			vlam_pkg::ST_HHI: begin
				mul_a = {1'b0, acc_q[vlam_pkg::KEY_W-1:vlam_pkg::MULT_W]};
				mul_b = {1'b0, mult_q};
			end
			vlam_pkg::ST_CMUL: begin
				mul_a = {cur_q.cent[ax_q][vlam_pkg::COORD_W-1], cur_q.cent[ax_q]};
				mul_b = {{(vlam_pkg::MUL_W - vlam_pkg::INV_W){1'b0}}, inv_q};
			end
			default: ;
		endcase
	end

	assign mul_full = mul_a * mul_b;

	// scaled index: floor of product, hash index one lower on an exact negative
	assign shr   = mul_q >>> vlam_pkg::FRAC_SHIFT;
	assign fl    = shr[vlam_pkg::IDX_W-1:0];
	assign exact = (mul_q[vlam_pkg::FRAC_SHIFT-1:0] == '0);
	assign hx    = fl - {{(vlam_pkg::IDX_W-1){1'b0}}, mul_q[vlam_pkg::KEY_W-1] & exact};

	// restoring modulo step
	always_comb begin
		rem_sh = {rem_q[vlam_pkg::KEY_W-2:0], acc_q[vlam_pkg::KEY_W-1]};
		if (rem_sh >= {1'b0, mod_q}) begin
			rem_sh = rem_sh - {1'b0, mod_q};
		end
	end

	// divider step and finish
	always_comb begin
		drem_sh = {drem_q, dq_q[vlam_pkg::SUM_W-1]};
		sum_sel = cur_q.sum[ax_q];
		sum_mag = sum_sel[vlam_pkg::SUM_W-1] ? (~sum_sel + vlam_pkg::SUM_W'(1)) : sum_sel;
		q_plus  = dq_q + {{(vlam_pkg::SUM_W-1){1'b0}}, drem_q != '0};
		cent_full = dneg_q ? (~q_plus + vlam_pkg::SUM_W'(1)) : dq_q;
	end

	// insertion decision
	always_comb begin
		cap_eff = vlam_pkg::CMP_W'(cap_q);
		if (cap_eff < vlam_pkg::CMP_W'(2)) cap_eff = vlam_pkg::CMP_W'(2);
		if (cap_eff > vlam_pkg::CMP_W'(vlam_pkg::TABLE_DEPTH)) begin
			cap_eff = vlam_pkg::CMP_W'(vlam_pkg::TABLE_DEPTH);
		end
		occ_next = vlam_pkg::CMP_W'(occ_q) + vlam_pkg::CMP_W'(1);
		ev_full  = !hit_q && !free_q;
		cap_ev   = !hit_q && free_q && tail_q && (occ_next >= cap_eff);
	end

	// record written back and result status
	always_comb begin
		new_entry = cur_q;
		if (!hit_q || mism_q) begin
			new_entry.count = vlam_pkg::COUNT_W'(1);
			for (int a = 0; a < 3; a++) begin
				new_entry.sum[a]  = {{(vlam_pkg::SUM_W - vlam_pkg::COORD_W){pt_q[a][vlam_pkg::COORD_W-1]}},
					pt_q[a]};
				new_entry.cent[a] = pt_q[a];
			end
		end
		data_wdata = new_entry;
		if (!hit_q) begin
			status_d = vlam_pkg::STATUS_NEW;
		end else if (mism_q) begin
			status_d = vlam_pkg::STATUS_REPLACED;
		end else if (full_q) begin
			status_d = vlam_pkg::STATUS_FULL;
		end else begin
			status_d = vlam_pkg::STATUS_ACCUM;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= vlam_pkg::ST_INIT;
			ctr_q     <= '0;
			ax_q      <= '0;
			rnd_q     <= 1'b0;
			step_q    <= '0;
			rd_vld_s1 <= 1'b0;
			occ_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			st_q      <= st_d;
			rd_vld_s1 <= meta_re;
			// output register loads when free or drained in the same cycle
			if (st_q == vlam_pkg::ST_EMIT && (!out_vld_q || results.ready)) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
			case (st_q)
				vlam_pkg::ST_INIT, vlam_pkg::ST_SCAN, vlam_pkg::ST_RANK: begin
					ctr_q <= ctr_q + vlam_pkg::ADDR_W'(1);
				end
				vlam_pkg::ST_CLEAR: begin
					ctr_q <= ctr_q + vlam_pkg::ADDR_W'(1);
					occ_q <= '0;
				end
				vlam_pkg::ST_IDLE: begin
					ctr_q <= '0;
					ax_q  <= '0;
					rnd_q <= 1'b0;
				end
				vlam_pkg::ST_SCALE_W, vlam_pkg::ST_CMUL_W, vlam_pkg::ST_DIVFIN: begin
					ax_q <= ax_q + 2'd1;
				end
				vlam_pkg::ST_HSUM:  step_q <= '0;
				vlam_pkg::ST_MOD:   step_q <= step_q + vlam_pkg::STEP_W'(1);
				vlam_pkg::ST_HNEXT: begin
					rnd_q <= 1'b1;
					ctr_q <= '0;
				end
				vlam_pkg::ST_DECIDE: begin
					ctr_q <= '0;
					if (!hit_q && !ev_full && !cap_ev) begin
						occ_q <= vlam_pkg::OCC_W'(occ_next);
					end
				end
				vlam_pkg::ST_DLAT, vlam_pkg::ST_CHK: ax_q <= '0;
				vlam_pkg::ST_DIVSET: step_q <= '0;
				vlam_pkg::ST_DIV:    step_q <= step_q + vlam_pkg::STEP_W'(1);
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q      <= mul_full[vlam_pkg::KEY_W-1:0];
		rd_addr_s1 <= ctr_q;

		// table scan compare, one entry a cycle
		if (rd_vld_s1 && (st_q == vlam_pkg::ST_SCAN || st_q == vlam_pkg::ST_SCAN_END)) begin
			if (meta_rd.valid && meta_rd.key == key_q && !hit_q) begin
				hit_q      <= 1'b1;
				hit_slot_q <= rd_addr_s1;
				hit_rank_q <= meta_rd.rank;
			end
			if (!meta_rd.valid && !free_q) begin
				free_q      <= 1'b1;
				free_slot_q <= rd_addr_s1;
			end
			if (meta_rd.valid && (!tail_q || meta_rd.rank > tail_rank_q)) begin
				tail_q      <= 1'b1;
				tail_slot_q <= rd_addr_s1;
				tail_rank_q <= meta_rd.rank;
				tail_key_q  <= meta_rd.key;
			end
		end

		case (st_q)
			vlam_pkg::ST_IDLE: begin
				pt_q[0]  <= points.point_x;
				pt_q[1]  <= points.point_y;
				pt_q[2]  <= points.point_z;
				// a clear reports only its status
				res_q    <= {vlam_pkg::STATUS_CLEARED,
					{($bits(vlam_pkg::res_t) - vlam_pkg::STATUS_W){1'b0}}};
			end
			vlam_pkg::ST_SCALE_W: begin
				fidx_q[ax_q] <= fl;
				hidx_q[ax_q] <= hx;
				// z is the last axis and seeds the hash
				acc_q <= {{(vlam_pkg::KEY_W - vlam_pkg::IDX_W){hx[vlam_pkg::IDX_W-1]}}, hx};
			end
			vlam_pkg::ST_HHI: acc_q <= mul_q;
			vlam_pkg::ST_HSUM: begin
				acc_q <= acc_q + {mul_q[vlam_pkg::MULT_W-1:0], {vlam_pkg::MULT_W{1'b0}}};
				rem_q <= '0;
			end
			vlam_pkg::ST_MOD: begin
				rem_q <= rem_sh;
				if (step_q == vlam_pkg::STEP_W'(vlam_pkg::KEY_W - 1)) begin
					acc_q <= rem_sh;
				end else begin
					acc_q <= {acc_q[vlam_pkg::KEY_W-2:0], 1'b0};
				end
			end
			vlam_pkg::ST_HNEXT: begin
				if (!rnd_q) begin
					acc_q <= acc_q + {{(vlam_pkg::KEY_W - vlam_pkg::IDX_W){hidx_q[1][vlam_pkg::IDX_W-1]}},
						hidx_q[1]};
				end else begin
					key_q <= acc_q + {{(vlam_pkg::KEY_W - vlam_pkg::IDX_W){hidx_q[0][vlam_pkg::IDX_W-1]}},
						hidx_q[0]};
				end
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				tail_q <= 1'b0;
			end
			vlam_pkg::ST_DECIDE: begin
				slot_q   <= hit_q ? hit_slot_q : (free_q ? free_slot_q : tail_slot_q);
				ev_q     <= ev_full || cap_ev;
				cap_ev_q <= cap_ev;
			end
			vlam_pkg::ST_DLAT: begin
				cur_q  <= data_rd;
				mism_q <= 1'b0;
				full_q <= 1'b0;
			end
			vlam_pkg::ST_CMUL_W: begin
				if (fl != fidx_q[ax_q]) mism_q <= 1'b1;
			end
			vlam_pkg::ST_CHK: begin
				if (cur_q.count < vlam_pkg::COUNT_W'(vlam_pkg::MAX_POINTS)) begin
					cur_q.count <= cur_q.count + vlam_pkg::COUNT_W'(1);
					for (int a = 0; a < 3; a++) begin
						cur_q.sum[a] <= cur_q.sum[a] +
							{{(vlam_pkg::SUM_W - vlam_pkg::COORD_W){pt_q[a][vlam_pkg::COORD_W-1]}},
							pt_q[a]};
					end
				end else begin
					full_q <= 1'b1;
				end
			end
			vlam_pkg::ST_DIVSET: begin
				dq_q   <= sum_mag;
				drem_q <= '0;
				dneg_q <= sum_sel[vlam_pkg::SUM_W-1];
			end
			vlam_pkg::ST_DIV: begin
				if (drem_sh >= {1'b0, cur_q.count}) begin
					drem_q <= vlam_pkg::COUNT_W'(drem_sh - {1'b0, cur_q.count});
					dq_q   <= {dq_q[vlam_pkg::SUM_W-2:0], 1'b1};
				end else begin
					drem_q <= drem_sh[vlam_pkg::COUNT_W-1:0];
					dq_q   <= {dq_q[vlam_pkg::SUM_W-2:0], 1'b0};
				end
			end
			vlam_pkg::ST_DIVFIN: cur_q.cent[ax_q] <= cent_full[vlam_pkg::COORD_W-1:0];
			vlam_pkg::ST_WRITE: begin
				res_q.status      <= status_d;
				res_q.key         <= key_q;
				res_q.count       <= new_entry.count;
				res_q.cent_x      <= new_entry.cent[0];
				res_q.cent_y      <= new_entry.cent[1];
				res_q.cent_z      <= new_entry.cent[2];
				res_q.evicted     <= ev_q;
				res_q.evicted_key <= ev_q ? tail_key_q : '0;
			end
			vlam_pkg::ST_EMIT: begin
				if (!out_vld_q || results.ready) out_q <= res_q;
			end
			default: ;
		endcase
	end

	// result channel
	assign results.valid       = out_vld_q;
	assign results.status      = out_q.status;
	assign results.voxel_key   = out_q.key;
	assign results.voxel_count = out_q.count;
	assign results.centroid_x  = out_q.cent_x;
	assign results.centroid_y  = out_q.cent_y;
	assign results.centroid_z  = out_q.cent_z;
	assign results.evicted     = out_q.evicted;
	assign results.evicted_key = out_q.evicted_key;

endmodule
`default_nettype wire
